### src/tvp_pkg.sv
// shared types and constants for the trapezoidal velocity profile generator
package tvp_pkg;

  localparam logic KIND_PLAN = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [31:0] ACCEL_TIME_RESET = 32'h0001_0000;
  localparam logic [14:0] PROG_FULL        = 15'd25600;
  localparam int          MAX_EVAL         = 8;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV48,
    OP_DIV64,
    OP_SQRT
  } tvp_op_t;

  typedef enum logic [1:0] {
    SEG_UP,
    SEG_CRUISE,
    SEG_DOWN
  } tvp_seg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_P_END,
    S_P_DIST,
    S_P_CHECK,
    S_P_ACC,
    S_P_BOUND,
    S_P_SQV,
    S_P_SQ0,
    S_P_SQF,
    S_P_X1,
    S_P_X2,
    S_P_SHAPE,
    S_P_AD,
    S_P_ROOT,
    S_P_TC,
    S_P_T1,
    S_P_T2,
    S_P_TF,
    S_P_DX,
    S_P_CR,
    S_P_SAVE,
    S_P_OUT,
    S_E_LOAD,
    S_E_SEG,
    S_E_MA,
    S_E_M1,
    S_E_M2,
    S_E_POS,
    S_E_PM,
    S_E_PD,
    S_E_OUT
  } tvp_state_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  axis;
    logic [31:0] start_position;
    logic [31:0] end_position;
    logic        end_is_absolute;
    logic [31:0] start_velocity;
    logic [31:0] end_velocity;
    logic [31:0] max_speed;
    logic [31:0] eval_time;
  } tvp_in_t;

  typedef struct packed {
    logic [2:0]  axis_index;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic [14:0] progress;
    logic        status;
    logic        last;
  } tvp_out_t;

endpackage

### src/tvp_arith.sv
// shared arithmetic unit: registered multiply, bit-serial divide, bit-serial square root
module tvp_arith (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tvp_pkg::tvp_op_t op,
  input  logic [63:0]      opa,
  input  logic [31:0]      opb,
  output logic [63:0]      res,
  output logic             done
);
  import tvp_pkg::*;

  logic        running;
  tvp_op_t     mode;
  logic [5:0]  cnt;
  logic [63:0] num;
  logic [63:0] quo;
  logic [63:0] sbit;
  logic [31:0] rem;
  logic [31:0] den;

  logic [64:0] prod;
  logic [32:0] shifted;
  logic        div_ge;
  logic [31:0] rem_next;
  logic [63:0] quo_div_next;
  logic [63:0] trial;
  logic        sq_ge;
  logic [63:0] num_sq_next;
  logic [63:0] quo_sq_next;

  assign prod         = opa[32:0] * opb;
  assign shifted      = {rem, num[63]};
  assign div_ge       = shifted >= {1'b0, den};
  assign rem_next     = div_ge ? 32'(shifted - {1'b0, den}) : shifted[31:0];
  assign quo_div_next = {quo[62:0], div_ge};
  assign trial        = quo + sbit;
  assign sq_ge        = num >= trial;
  assign num_sq_next  = sq_ge ? num - trial : num;
  assign quo_sq_next  = sq_ge ? (quo >> 1) + sbit : quo >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= (op != OP_MUL);
        done    <= (op == OP_MUL);
      end else if (running && cnt == 6'd0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode <= op;
      rem  <= '0;
      quo  <= '0;
      den  <= opb;
      case (op)
        OP_MUL: begin
          res <= prod[63:0];
        end
        OP_DIV48: begin
          num <= {opa[47:0], 16'h0000};
          cnt <= 6'd47;
        end
        OP_DIV64: begin
          num <= opa;
          cnt <= 6'd63;
        end
        OP_SQRT: begin
          num  <= opa;
          sbit <= 64'h4000_0000_0000_0000;
          cnt  <= 6'd31;
        end
        default: begin
          res <= '0;
        end
      endcase
    end else if (running) begin
      cnt <= cnt - 6'd1;
      if (mode == OP_SQRT) begin
        num  <= num_sq_next;
        quo  <= quo_sq_next;
        sbit <= sbit >> 2;
        if (cnt == 6'd0) res <= quo_sq_next;
      end else begin
        rem <= rem_next;
        num <= num << 1;
        quo <= quo_div_next;
        if (cnt == 6'd0) res <= quo_div_next;
      end
    end
  end

endmodule

### src/trapezoidal_velocity_profile.sv
// top level: multi-axis trapezoidal velocity profile generator, Q15.16
//
// channel   direction  handshake              payload
// command   in         start & !busy          item   (tvp_in_t)
// result    out        done, one-cycle strobe result (tvp_out_t)
// config    in         cfg_write              cfg_data -> accel_time
//
// a moving plan item runs three 48-step divides, two 64-step divides and either
// a 32-step square root (triangular) or one more 48-step divide (trapezoid), all
// in one shared arithmetic unit, plus setup, multiplies and storage; a rejected
// or zero-distance plan does not use the arithmetic unit
// an evaluate item runs per axis four (two in cruise) multiplies and one 48-step
// divide for progress; a stationary axis needs no arithmetic
// busy is high from accept until the last result is issued
// reset returns all axes to stationary at position zero, accel_time to 1.0 s
// results cannot be stalled: each sits on result for exactly the done cycle
module trapezoidal_velocity_profile #(
  parameter int N_AXES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tvp_pkg::tvp_in_t  item,
  input  logic              cfg_write,
  input  logic [31:0]       cfg_data,
  output logic              done,
  output tvp_pkg::tvp_out_t result
);
  import tvp_pkg::*;

  localparam int AXW    = (N_AXES > 1) ? $clog2(N_AXES) : 1;
  localparam int N_EVAL = (N_AXES < MAX_EVAL) ? N_AXES : MAX_EVAL;

  localparam logic signed [49:0] S32_MAX50 = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN50 = -50'sd2147483648;

  // signed base plus a signed magnitude, saturated to 32 bits
  function automatic logic [31:0] add_sat(input logic [31:0] base, input logic neg,
                                          input logic [47:0] mag);
    logic [49:0] ext;
    logic [49:0] sum;
    ext = {2'b00, mag};
    sum = {{18{base[31]}}, base} + (neg ? (~ext + 50'd1) : ext);
    if ($signed(sum) > S32_MAX50) begin
      add_sat = 32'h7fff_ffff;
    end else if ($signed(sum) < S32_MIN50) begin
      add_sat = 32'h8000_0000;
    end else begin
      add_sat = sum[31:0];
    end
  endfunction

  // boundary speed along the motion, zero if against it or above max speed
  function automatic logic [31:0] boundary(input logic neg, input logic [31:0] v,
                                           input logic [31:0] vm);
    logic [32:0] t;
    t = neg ? (~{v[31], v} + 33'd1) : {v[31], v};
    if (!t[32] && t[31:0] <= vm) begin
      boundary = t[31:0];
    end else begin
      boundary = '0;
    end
  endfunction

  function automatic logic [31:0] sat31(input logic [63:0] x);
    sat31 = (x > 64'h7fff_ffff) ? 32'h7fff_ffff : x[31:0];
  endfunction

  // control
  tvp_state_t state, state_next;
  logic       pend;
  logic [31:0] accel_time;

  // shared unit
  logic        u_start;
  tvp_op_t     u_op;
  logic [63:0] u_opa;
  logic [31:0] u_opb;
  logic [63:0] u_res;
  logic        u_done;

  // working registers
  tvp_in_t     cmd;
  logic [31:0] qf;
  logic [31:0] d;
  logic        neg;
  logic [31:0] vmax;
  logic [31:0] a;
  logic [31:0] v0p;
  logic [31:0] vfp;
  logic [63:0] vm2;
  logic [63:0] s0;
  logic [63:0] sf;
  logic [63:0] x1;
  logic [63:0] x2;
  logic [63:0] hs;
  logic [63:0] rq;
  logic [31:0] peak;
  logic [31:0] tc;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] tf;
  logic [31:0] p1;
  logic [31:0] p2;
  logic        p_status;
  logic [AXW-1:0] eidx;
  logic [31:0] tt;
  logic [31:0] tau;
  logic [31:0] at;
  tvp_seg_t    seg;
  logic        ended;
  logic [63:0] prod1;
  logic [31:0] pos;
  logic [31:0] vel;
  logic [31:0] acc;
  logic [14:0] prog;

  // per-axis state
  logic        stat_arr  [N_AXES];
  logic        negd_arr  [N_AXES];
  logic [31:0] orig_arr  [N_AXES];
  logic [31:0] p1_arr    [N_AXES];
  logic [31:0] p2_arr    [N_AXES];
  logic [31:0] entry_arr [N_AXES];
  logic [31:0] peak_arr  [N_AXES];
  logic [31:0] amag_arr  [N_AXES];
  logic [31:0] t1_arr    [N_AXES];
  logic [31:0] tc_arr    [N_AXES];
  logic [31:0] tf_arr    [N_AXES];

  // helper wires
  logic [AXW-1:0] slot;
  logic           ax_ok;
  logic [32:0]    qsum;
  logic [31:0]    qf_sum;
  logic [32:0]    dq;
  logic           vmax_bad;
  logic [31:0]    ta;
  logic [64:0]    x12;
  logic           tri_shape;
  logic [31:0]    dtc;
  logic [32:0]    tsum;
  logic [31:0]    pk_min;
  logic [31:0]    lo;
  logic [47:0]    at_raw;
  logic           flat;
  logic [31:0]    tt_clamp;
  logic           ended_now;
  tvp_seg_t       seg_sel;
  logic [32:0]    t1tc;
  logic [47:0]    travel;
  logic [31:0]    base;
  logic [32:0]    vmag;
  logic           last_axis;

  assign slot     = AXW'(cmd.axis);
  assign ax_ok    = {2'b00, cmd.axis} < 5'(N_AXES);
  assign qsum     = {cmd.start_position[31], cmd.start_position}
                  + {cmd.end_position[31], cmd.end_position};
  assign qf_sum   = (qsum[32] != qsum[31]) ? (qsum[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                           : qsum[31:0];
  assign dq       = {qf[31], qf} - {cmd.start_position[31], cmd.start_position};
  assign vmax_bad = cmd.max_speed[31] || (cmd.max_speed == 32'd0);
  assign ta       = (accel_time == 32'd0) ? 32'd1 : accel_time;
  assign x12      = {1'b0, x1} + {1'b0, x2};
  assign tri_shape = x12 >= {33'd0, d};
  assign dtc      = d - x1[31:0] - x2[31:0];
  assign tsum     = {1'b0, t1} + {1'b0, tc} + {1'b0, t2};
  assign lo       = (v0p > vfp) ? v0p : vfp;
  assign pk_min   = (u_res > {32'd0, vmax}) ? vmax : u_res[31:0];
  assign at_raw   = u_res[63:16];
  assign last_axis = (eidx == AXW'(N_EVAL - 1));

  // evaluate: clamp time into the profile and pick the phase
  assign flat      = stat_arr[eidx] || (tf_arr[eidx] == 32'd0);
  assign tt_clamp  = cmd.eval_time[31] ? 32'd0
                   : ((cmd.eval_time > tf_arr[eidx]) ? tf_arr[eidx] : cmd.eval_time);
  assign ended_now = !cmd.eval_time[31] && (cmd.eval_time >= tf_arr[eidx]);
  assign t1tc      = {1'b0, t1} + {1'b0, tc};

  always_comb begin
    if (tt <= t1) begin
      seg_sel = SEG_UP;
    end else if ({1'b0, tt} <= t1tc) begin
      seg_sel = SEG_CRUISE;
    end else begin
      seg_sel = SEG_DOWN;
    end
  end

  always_comb begin
    case (seg)
      SEG_UP: begin
        travel = 48'((prod1 + (u_res >> 1)) >> 16);
        base   = orig_arr[eidx];
        vmag   = {1'b0, v0p} + {1'b0, at};
      end
      SEG_CRUISE: begin
        travel = 48'(prod1 >> 16);
        base   = p1_arr[eidx];
        vmag   = {1'b0, peak};
      end
      default: begin
        travel = 48'((prod1 - (u_res >> 1)) >> 16);
        base   = p2_arr[eidx];
        vmag   = {1'b0, peak - at};
      end
    endcase
  end

  // shared arithmetic unit
  tvp_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .op    (u_op),
    .opa   (u_opa),
    .opb   (u_opb),
    .res   (u_res),
    .done  (u_done)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend       <= 1'b0;
      accel_time <= ACCEL_TIME_RESET;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      if (u_start) begin
        pend <= 1'b1;
      end else if (u_done) begin
        pend <= 1'b0;
      end
      if (cfg_write) accel_time <= cfg_data;
      done <= (state == S_P_OUT) || (state == S_E_OUT);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start) state_next = (item.kind == KIND_EVAL) ? S_E_LOAD : S_P_END;
      S_P_END:   state_next = S_P_DIST;
      S_P_DIST:  state_next = S_P_CHECK;
      S_P_CHECK: state_next = (!ax_ok || d == 32'd0 || vmax_bad) ? S_P_OUT : S_P_ACC;
      S_P_ACC:   if (u_done) state_next = S_P_BOUND;
      S_P_BOUND: state_next = S_P_SQV;
      S_P_SQV:   if (u_done) state_next = S_P_SQ0;
      S_P_SQ0:   if (u_done) state_next = S_P_SQF;
      S_P_SQF:   if (u_done) state_next = S_P_X1;
      S_P_X1:    if (u_done) state_next = S_P_X2;
      S_P_X2:    if (u_done) state_next = S_P_SHAPE;
      S_P_SHAPE: state_next = tri_shape ? S_P_AD : S_P_TC;
      S_P_AD:    if (u_done) state_next = S_P_ROOT;
      S_P_ROOT:  if (u_done) state_next = S_P_T1;
      S_P_TC:    if (u_done) state_next = S_P_T1;
      S_P_T1:    if (u_done) state_next = S_P_T2;
      S_P_T2:    if (u_done) state_next = S_P_TF;
      S_P_TF:    state_next = S_P_DX;
      S_P_DX:    if (u_done) state_next = S_P_CR;
      S_P_CR:    if (u_done) state_next = S_P_SAVE;
      S_P_SAVE:  state_next = S_P_OUT;
      S_P_OUT:   state_next = S_IDLE;
      S_E_LOAD:  state_next = flat ? S_E_OUT : S_E_SEG;
      S_E_SEG:   state_next = (seg_sel == SEG_CRUISE) ? S_E_M1 : S_E_MA;
      S_E_MA:    if (u_done) state_next = S_E_M1;
      S_E_M1:    if (u_done) state_next = (seg == SEG_CRUISE) ? S_E_POS : S_E_M2;
      S_E_M2:    if (u_done) state_next = S_E_POS;
      S_E_POS:   state_next = S_E_PM;
      S_E_PM:    if (u_done) state_next = S_E_PD;
      S_E_PD:    if (u_done) state_next = S_E_OUT;
      S_E_OUT:   state_next = last_axis ? S_IDLE : S_E_LOAD;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs: busy and the operand mux of the shared unit
  always_comb begin
    busy    = (state != S_IDLE);
    u_start = 1'b0;
    u_op    = OP_MUL;
    u_opa   = '0;
    u_opb   = '0;
    case (state)
      S_P_ACC: begin
        u_start = !pend;
        u_op    = OP_DIV48;
        u_opa   = 64'({vmax, 16'h0000});
        u_opb   = ta;
      end
      S_P_SQV: begin
        u_start = !pend;
        u_opa   = 64'(vmax);
        u_opb   = vmax;
      end
      S_P_SQ0: begin
        u_start = !pend;
        u_opa   = 64'(v0p);
        u_opb   = v0p;
      end
      S_P_SQF: begin
        u_start = !pend;
        u_opa   = 64'(vfp);
        u_opb   = vfp;
      end
      S_P_X1: begin
        u_start = !pend;
        u_op    = OP_DIV64;
        u_opa   = vm2 - s0;
        u_opb   = {a[30:0], 1'b0};
      end
      S_P_X2: begin
        u_start = !pend;
        u_op    = OP_DIV64;
        u_opa   = vm2 - sf;
        u_opb   = {a[30:0], 1'b0};
      end
      S_P_AD: begin
        u_start = !pend;
        u_opa   = 64'(a);
        u_opb   = d;
      end
      S_P_ROOT: begin
        u_start = !pend;
        u_op    = OP_SQRT;
        u_opa   = rq + hs;
      end
      S_P_TC: begin
        u_start = !pend;
        u_op    = OP_DIV48;
        u_opa   = 64'({dtc, 16'h0000});
        u_opb   = vmax;
      end
      S_P_T1: begin
        u_start = !pend;
        u_op    = OP_DIV48;
        u_opa   = 64'({peak - v0p, 16'h0000});
        u_opb   = a;
      end
      S_P_T2: begin
        u_start = !pend;
        u_op    = OP_DIV48;
        u_opa   = 64'({peak - vfp, 16'h0000});
        u_opb   = a;
      end
      S_P_DX: begin
        u_start = !pend;
        u_opa   = 64'({1'b0, v0p} + {1'b0, peak});
        u_opb   = t1;
      end
      S_P_CR: begin
        u_start = !pend;
        u_opa   = 64'(peak);
        u_opb   = tc;
      end
      S_E_MA: begin
        u_start = !pend;
        u_opa   = 64'(a);
        u_opb   = tau;
      end
      S_E_M1: begin
        u_start = !pend;
        u_opa   = (seg == SEG_UP) ? 64'(v0p) : 64'(peak);
        u_opb   = tau;
      end
      S_E_M2: begin
        u_start = !pend;
        u_opa   = 64'(at);
        u_opb   = tau;
      end
      S_E_PM: begin
        u_start = !pend;
        u_opa   = 64'(tt);
        u_opb   = 32'(PROG_FULL);
      end
      S_E_PD: begin
        u_start = !pend;
        u_op    = OP_DIV48;
        u_opa   = u_res;
        u_opb   = tf;
      end
      default: begin
        u_start = 1'b0;
      end
    endcase
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd  <= item;
          eidx <= '0;
        end
      end
      S_P_END: qf <= cmd.end_is_absolute ? cmd.end_position : qf_sum;
      S_P_DIST: begin
        neg  <= dq[32];
        d    <= dq[32] ? 32'(~dq + 33'd1) : dq[31:0];
        vmax <= cmd.max_speed;
      end
      S_P_CHECK: p_status <= ax_ok && (d != 32'd0) && vmax_bad;
      S_P_ACC: begin
        if (u_done) begin
          // ramp acceleration kept at least one lsb and within the signed range
          if (u_res == 64'd0) begin
            a <= 32'd1;
          end else begin
            a <= sat31(u_res);
          end
        end
      end
      S_P_BOUND: begin
        v0p <= boundary(neg, cmd.start_velocity, vmax);
        vfp <= boundary(neg, cmd.end_velocity, vmax);
      end
      S_P_SQV: if (u_done) vm2 <= u_res;
      S_P_SQ0: if (u_done) s0 <= u_res;
      S_P_SQF: if (u_done) sf <= u_res;
      S_P_X1:  if (u_done) x1 <= u_res;
      S_P_X2:  if (u_done) x2 <= u_res;
      S_P_SHAPE: begin
        hs <= 64'(({1'b0, s0} + {1'b0, sf}) >> 1);
        // triangular when the ramps alone cover the distance
        if (tri_shape) begin
          tc <= '0;
        end else begin
          peak <= vmax;
        end
      end
      S_P_AD: if (u_done) rq <= u_res;
      S_P_ROOT: begin
        // reduced peak held between the larger boundary speed and max speed
        if (u_done) peak <= (pk_min < lo) ? lo : pk_min;
      end
      S_P_TC: if (u_done) tc <= sat31(u_res);
      S_P_T1: if (u_done) t1 <= sat31(u_res);
      S_P_T2: if (u_done) t2 <= sat31(u_res);
      S_P_TF: tf <= tsum[32] ? 32'hffff_ffff : tsum[31:0];
      S_P_DX: if (u_done) p1 <= add_sat(cmd.start_position, neg, 48'(u_res >> 17));
      S_P_CR: if (u_done) p2 <= add_sat(p1, neg, 48'(u_res >> 16));
      S_E_LOAD: begin
        a     <= amag_arr[eidx];
        v0p   <= entry_arr[eidx];
        peak  <= peak_arr[eidx];
        t1    <= t1_arr[eidx];
        tc    <= tc_arr[eidx];
        tf    <= tf_arr[eidx];
        neg   <= negd_arr[eidx];
        tt    <= tt_clamp;
        ended <= ended_now;
        if (flat) begin
          pos  <= orig_arr[eidx];
          vel  <= '0;
          acc  <= '0;
          prog <= PROG_FULL;
        end
      end
      S_E_SEG: begin
        seg <= seg_sel;
        case (seg_sel)
          SEG_UP:     tau <= tt;
          SEG_CRUISE: tau <= tt - t1;
          default:    tau <= tt - t1 - tc;
        endcase
      end
      S_E_MA: begin
        if (u_done) begin
          if (seg == SEG_DOWN && at_raw > {16'd0, peak}) begin
            at <= peak;
          end else begin
            at <= at_raw[31:0];
          end
        end
      end
      S_E_M1: if (u_done) prod1 <= u_res;
      S_E_POS: begin
        pos <= add_sat(base, neg, travel);
        vel <= ended ? 32'd0 : add_sat(32'd0, neg, 48'(vmag));
        if (ended || seg == SEG_CRUISE) begin
          acc <= '0;
        end else if ((seg == SEG_UP) != neg) begin
          acc <= a;
        end else begin
          acc <= ~a + 32'd1;
        end
      end
      S_E_PD: if (u_done) prog <= u_res[14:0];
      S_E_OUT: eidx <= eidx + AXW'(1);
      default: begin
        tt <= tt;
      end
    endcase
  end

  // per-axis flags and origin, reset to a stationary axis at position zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_AXES; i++) begin
        stat_arr[i] <= 1'b1;
        negd_arr[i] <= 1'b0;
        orig_arr[i] <= '0;
      end
    end else if (state == S_P_CHECK && ax_ok && d == 32'd0) begin
      // zero distance: axis parks at the start position
      stat_arr[slot] <= 1'b1;
      negd_arr[slot] <= 1'b0;
      orig_arr[slot] <= cmd.start_position;
    end else if (state == S_P_SAVE) begin
      stat_arr[slot] <= 1'b0;
      negd_arr[slot] <= neg;
      orig_arr[slot] <= cmd.start_position;
    end
  end

  // per-axis profile coefficients, only read after a moving plan
  always_ff @(posedge clk) begin
    if (state == S_P_SAVE) begin
      p1_arr[slot]    <= p1;
      p2_arr[slot]    <= p2;
      entry_arr[slot] <= v0p;
      peak_arr[slot]  <= peak;
      amag_arr[slot]  <= a;
      t1_arr[slot]    <= t1;
      tc_arr[slot]    <= tc;
      tf_arr[slot]    <= tf;
    end
  end

  // result register, valid in the one cycle that done is high
  always_ff @(posedge clk) begin
    if (state == S_P_OUT) begin
      result.axis_index   <= cmd.axis;
      result.position     <= '0;
      result.velocity     <= '0;
      result.acceleration <= '0;
      result.progress     <= '0;
      result.status       <= p_status ? STATUS_REJECT : STATUS_OK;
      result.last         <= 1'b1;
    end else if (state == S_E_OUT) begin
      result.axis_index   <= 3'(eidx);
      result.position     <= pos;
      result.velocity     <= vel;
      result.acceleration <= acc;
      result.progress     <= prog;
      result.status       <= STATUS_OK;
      result.last         <= last_axis;
    end
  end

endmodule

### test/tb.sv
// testbench for the trapezoidal velocity profile generator: random and directed items
`timescale 1ns / 100ps

module tb;
  import tvp_pkg::*;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tvp_in_t item = '0;
  logic cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic done;
  tvp_out_t result;

  trapezoidal_velocity_profile u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done), .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state, one entry per axis
  logic [31:0] at_reg;
  logic        ax_still [8];
  logic        ax_neg [8];
  logic [31:0] ax_org [8];
  logic [31:0] ax_p1 [8];
  logic [31:0] ax_p2 [8];
  logic [31:0] ax_v0 [8];
  logic [31:0] ax_pk [8];
  logic [31:0] ax_acc [8];
  logic [31:0] ax_t1 [8];
  logic [31:0] ax_tc [8];
  logic [31:0] ax_tf [8];

  tvp_in_t  pending_items [$];
  tvp_out_t profile_results [$];

  int idle_pct = 0;
  bit hold_send = 1'b0;
  int n_bad = 0;
  longint cyc = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint with_dir(bit neg, longint mag);
    return neg ? -mag : mag;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // boundary speed along the motion, zero if against it or above max speed
  function automatic longint unsigned edge_speed(bit neg, longint v, longint unsigned vm);
    longint t;
    t = neg ? -v : v;
    return (t >= 0 && longint'(t) <= longint'(vm)) ? longint'(t) : 0;
  endfunction

  // plan one axis, returns the status bit
  function automatic logic plan_motion(tvp_in_t it);
    int ax;
    longint q0, e, qf, vm, p1, p2;
    longint unsigned d, vmax, ta, a, v0, vf, x1, x2, peak, t1, tc, t2, tf, lo, dx;
    bit neg;
    ax = it.axis;
    q0 = longint'($signed(it.start_position));
    e = longint'($signed(it.end_position));
    qf = clip32(it.end_is_absolute ? e : q0 + e);
    vm = longint'($signed(it.max_speed));
    d = qf > q0 ? qf - q0 : q0 - qf;
    if (d == 0) begin
      ax_still[ax] = 1'b1;
      ax_neg[ax] = 1'b0;
      ax_org[ax] = q0[31:0];
      ax_p1[ax] = q0[31:0];
      ax_p2[ax] = q0[31:0];
      ax_v0[ax] = '0; ax_pk[ax] = '0; ax_acc[ax] = '0;
      ax_t1[ax] = '0; ax_tc[ax] = '0; ax_tf[ax] = '0;
      return STATUS_OK;
    end
    if (vm <= 0) return STATUS_REJECT;
    neg = qf < q0;
    vmax = vm;
    ta = (at_reg == 0) ? 1 : at_reg;
    a = (vmax << 16) / ta;
    if (a < 1) a = 1;
    if (a > 64'd2147483647) a = 64'd2147483647;
    v0 = edge_speed(neg, longint'($signed(it.start_velocity)), vmax);
    vf = edge_speed(neg, longint'($signed(it.end_velocity)), vmax);
    x1 = (vmax * vmax - v0 * v0) / (2 * a);
    x2 = (vmax * vmax - vf * vf) / (2 * a);
    // short move: triangular profile with reduced peak
    if (x1 + x2 >= d) begin
      peak = root64(a * d + ((v0 * v0 + vf * vf) >> 1));
      lo = v0 > vf ? v0 : vf;
      if (peak > vmax) peak = vmax;
      if (peak < lo) peak = lo;
      tc = 0;
    end else begin
      peak = vmax;
      tc = ((d - x1 - x2) << 16) / vmax;
      if (tc > 64'd2147483647) tc = 64'd2147483647;
    end
    t1 = ((peak - v0) << 16) / a;
    if (t1 > 64'd2147483647) t1 = 64'd2147483647;
    t2 = ((peak - vf) << 16) / a;
    if (t2 > 64'd2147483647) t2 = 64'd2147483647;
    tf = t1 + tc + t2;
    if (tf > 64'hFFFF_FFFF) tf = 64'hFFFF_FFFF;
    dx = ((v0 + peak) * t1) >> 17;
    p1 = clip32(q0 + with_dir(neg, dx));
    p2 = clip32(p1 + with_dir(neg, (peak * tc) >> 16));
    ax_still[ax] = 1'b0;
    ax_neg[ax] = neg;
    ax_org[ax] = q0[31:0];
    ax_p1[ax] = p1[31:0];
    ax_p2[ax] = p2[31:0];
    ax_v0[ax] = v0[31:0];
    ax_pk[ax] = peak[31:0];
    ax_acc[ax] = a[31:0];
    ax_t1[ax] = t1[31:0];
    ax_tc[ax] = tc[31:0];
    ax_tf[ax] = tf[31:0];
    return STATUS_OK;
  endfunction

  function automatic tvp_out_t sample_axis(int i, longint t);
    tvp_out_t r;
    longint pos, vel, acc, base;
    longint unsigned prog, tf, a, peak, t1, tc, tt, tau, at, travel;
    bit neg;
    vel = 0; acc = 0; prog = PROG_FULL;
    tf = ax_tf[i];
    if (ax_still[i] || tf == 0) begin
      pos = longint'($signed(ax_org[i]));
    end else begin
      neg = ax_neg[i];
      a = ax_acc[i]; peak = ax_pk[i]; t1 = ax_t1[i]; tc = ax_tc[i];
      tt = t < 0 ? 0 : (longint'(t) > longint'(tf) ? tf : t);
      if (tt <= t1) begin
        tau = tt;
        at = (a * tau) >> 16;
        acc = with_dir(neg, a);
        vel = with_dir(neg, ax_v0[i] + at);
        travel = (longint'(ax_v0[i]) * tau + ((at * tau) >> 1)) >> 16;
        base = longint'($signed(ax_org[i]));
      end else if (tt <= t1 + tc) begin
        tau = tt - t1;
        vel = with_dir(neg, peak);
        travel = (peak * tau) >> 16;
        base = longint'($signed(ax_p1[i]));
      end else begin
        tau = tt - t1 - tc;
        at = (a * tau) >> 16;
        if (at > peak) at = peak;
        acc = -with_dir(neg, a);
        vel = with_dir(neg, peak - at);
        travel = (peak * tau - ((at * tau) >> 1)) >> 16;
        base = longint'($signed(ax_p2[i]));
      end
      pos = clip32(base + with_dir(neg, travel));
      vel = clip32(vel);
      if (t >= longint'(tf)) begin
        vel = 0;
        acc = 0;
      end
      prog = (tt * 25600) / tf;
    end
    r.axis_index = i[2:0];
    r.position = pos[31:0];
    r.velocity = vel[31:0];
    r.acceleration = acc[31:0];
    r.progress = prog[14:0];
    r.status = STATUS_OK;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_item(tvp_in_t it);
    tvp_out_t r;
    if (it.kind == KIND_PLAN) begin
      r = '0;
      r.axis_index = it.axis;
      r.status = plan_motion(it);
      r.last = 1'b1;
      profile_results.push_back(r);
    end else begin
      for (int i = 0; i < MAX_EVAL; i++) begin
        r = sample_axis(i, longint'($signed(it.eval_time)));
        r.last = (i == MAX_EVAL - 1);
        profile_results.push_back(r);
      end
    end
  endtask

  // driver: offer the next pending item unless idling or held
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_item(item);
      if ((!start || !busy) && !(start && busy)) begin
        if (pending_items.size() > 0 && !hold_send && $urandom_range(99) >= idle_pct) begin
          item <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst && done) begin
      if (profile_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %p", result);
      end else begin
        tvp_out_t w;
        w = profile_results.pop_front();
        if (result !== w) begin
          n_bad++;
          if (n_bad <= 10) $display("mismatch: expected %p actual %p", w, result);
        end
      end
    end
    if (cyc > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_field();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(1 << 20);
      3: return -$urandom_range(1 << 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic tvp_in_t rnd_plan();
    tvp_in_t it;
    logic [31:0] sp;
    it = '0;
    it.kind = KIND_PLAN;
    it.axis = $urandom_range(7);
    it.start_position = $urandom_range(3) == 0 ? rnd_field() : $signed($urandom_range(1 << 22)) - (1 << 21);
    it.end_is_absolute = $urandom_range(1);
    it.end_position = $urandom_range(5) == 0 ? rnd_field() :
                      $signed($urandom_range(1 << 22)) - (1 << 21);
    if ($urandom_range(15) == 0) it.end_position = it.end_is_absolute ? it.start_position : '0;
    sp = $urandom_range(5) == 0 ? rnd_field() : $urandom_range(1 << 20, 1);
    it.max_speed = sp;
    it.start_velocity = $urandom_range(3) == 0 ? rnd_field() : ($signed($urandom_range(sp[20:0])) * ($urandom_range(1) ? 1 : -1));
    it.end_velocity = $urandom_range(3) == 0 ? rnd_field() : ($signed($urandom_range(sp[20:0])) * ($urandom_range(1) ? 1 : -1));
    it.eval_time = $urandom();
    return it;
  endfunction

  function automatic tvp_in_t rnd_eval();
    tvp_in_t it;
    it = '0;
    it.kind = KIND_EVAL;
    it.axis = $urandom_range(7);
    it.start_position = $urandom();
    it.end_position = $urandom();
    it.end_is_absolute = $urandom_range(1);
    it.start_velocity = $urandom();
    it.end_velocity = $urandom();
    it.max_speed = $urandom();
    it.eval_time = $urandom_range(3) == 0 ? rnd_field() : $urandom_range(6 << 16);
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || start || busy || profile_results.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_accel_time(logic [31:0] v);
    drain();
    cfg_data <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    at_reg = v;
  endtask

  initial begin
    tvp_in_t it;
    at_reg = ACCEL_TIME_RESET;
    for (int i = 0; i < 8; i++) begin
      ax_still[i] = 1'b1; ax_neg[i] = 1'b0; ax_org[i] = '0;
      ax_p1[i] = '0; ax_p2[i] = '0; ax_v0[i] = '0; ax_pk[i] = '0;
      ax_acc[i] = '0; ax_t1[i] = '0; ax_tc[i] = '0; ax_tf[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: evaluate from reset, extremes, rejection, stationary, saturation
    it = rnd_eval(); it.eval_time = 32'h8000_0000; pending_items.push_back(it);
    it = '0; it.kind = KIND_PLAN; it.axis = 0; it.end_position = 32'h0004_0000;
    it.max_speed = 32'h0001_0000; pending_items.push_back(it);
    it.axis = 1; it.end_position = 32'h0000_1000; pending_items.push_back(it);
    it.axis = 2; it.end_position = 32'h0004_0000; it.max_speed = 0; pending_items.push_back(it);
    it.max_speed = 32'h8000_0000; pending_items.push_back(it);
    it.axis = 3; it.start_position = 32'h7FFF_0000; it.end_position = 32'h7FFF_FFFF;
    it.end_is_absolute = 1'b0; it.max_speed = 32'h7FFF_FFFF;
    it.start_velocity = 32'h7FFF_FFFF; it.end_velocity = 32'h8000_0000; pending_items.push_back(it);
    it.axis = 4; it.start_position = 32'h8000_0000; it.end_position = 32'h7FFF_FFFF;
    it.end_is_absolute = 1'b1; it.max_speed = 32'h0000_0001; pending_items.push_back(it);
    it.axis = 5; it.start_position = 32'h0010_0000; it.end_position = 32'hFFF0_0000;
    it.start_velocity = 32'hFFFF_0000; it.end_velocity = 32'hFFF8_0000;
    it.max_speed = 32'h0002_0000; pending_items.push_back(it);
    it.axis = 6; it.end_position = 32'h0010_0000; it.start_position = 32'h0010_0000;
    it.max_speed = 32'hFFFF_FFFF; pending_items.push_back(it);
    it.axis = 7; it.start_position = 0; it.end_position = 32'h0000_0800; it.end_is_absolute = 0;
    it.start_velocity = 32'h0003_0000; it.end_velocity = 32'h0003_0000;
    it.max_speed = 32'h0004_0000; pending_items.push_back(it);
    it = rnd_eval(); it.eval_time = 32'h8000_0000; pending_items.push_back(it);
    it.eval_time = 32'h0; pending_items.push_back(it);
    it.eval_time = 32'h0000_8000; pending_items.push_back(it);
    it.eval_time = 32'h0002_8000; pending_items.push_back(it);
    it.eval_time = 32'h7FFF_FFFF; pending_items.push_back(it);

    // pause until every result is in
    drain();
    hold_send = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_accel_time(32'h0000_8000);
        1: set_accel_time(32'hFFFF_FFFF);
        2: set_accel_time(32'h0000_0000);
        3: set_accel_time(32'h0000_0001);
        4: set_accel_time(32'h0002_0000);
        default: set_accel_time(ACCEL_TIME_RESET);
      endcase
      idle_pct = (ph < 2) ? 24 : (ph < 4 ? 55 : 0);
      for (int n = 0; n < 60; n++)
        pending_items.push_back(($urandom_range(2) == 0) ? rnd_eval() : rnd_plan());
    end

    drain();
    if (n_bad == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
